[design/hvt_pkg.sv]
// Package for the vote tally block: slot counts, derived widths, payload words,
// opcodes and status codes. No dependencies.
package hvt_pkg;

    localparam int CAND_SLOTS  = 256;
    localparam int VOTER_SLOTS = 256;
    localparam int KEY_BITS    = 32;

    localparam int CIDX_W = $clog2(CAND_SLOTS);
    localparam int VIDX_W = $clog2(VOTER_SLOTS);
    localparam int PIDX_W = (CIDX_W > VIDX_W) ? CIDX_W : VIDX_W;
    localparam int SZ_W   = PIDX_W + 1;
    localparam int CNT_W  = $clog2(KEY_BITS);
    localparam int CFG_W  = 9;
    localparam int VOTE_W = 16;

    localparam logic [1:0] OP_ADD_CAND  = 2'd0;
    localparam logic [1:0] OP_ADD_VOTER = 2'd1;
    localparam logic [1:0] OP_VOTE      = 2'd2;
    localparam logic [1:0] OP_FINISH    = 2'd3;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_FULL          = 3'd1;
    localparam logic [2:0] ST_UNKNOWN_VOTER = 3'd2;
    localparam logic [2:0] ST_ALREADY_VOTED = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_CAND  = 3'd4;
    localparam logic [2:0] ST_NO_CANDS      = 3'd5;

    localparam logic CFG_CAND_SIZE  = 1'b0;
    localparam logic CFG_VOTER_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key_val;
        logic [31:0] key_n;
        logic [31:0] cand_val;
        logic [31:0] cand_n;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] winner_val;
        logic [31:0] winner_n;
        logic [15:0] winner_votes;
    } rsp_t;

endpackage

[design/hash_vote_tally.sv]
// Top level of the vote tally: sequencer, shared modulo unit, probe logic.
// Depends on hvt_pkg and hvt_ram.
//
// A word is taken when start is high and busy is low. Exactly one result word
// follows on rsp, marked by a one-cycle done strobe in the first cycle with
// busy low; the strobe cannot be held off. Every add or vote first runs a
// bit-serial modulo of the key value by the table size. It then walks the
// table, each slot through S_PROBE and S_CMP, because the used flag and
// the key come back from a registered RAM read. An add stops on a free or
// matching slot after passing the occupied ones, or reports full when every
// slot is occupied. A vote runs one such walk for the voter and, when the
// voter may vote, a second one for the candidate. The used flags live in the
// key RAMs, so every finish ends with a clearing pass over both tables before
// its result leaves. A finish with candidates runs the seed count fetch, a
// scan of each slot below the candidate size, the end check, the winner fetch
// and the clearing pass. A finish without candidates holds busy for the
// clearing pass alone. After reset the same clearing pass runs with busy high.
// Size registers may be written only while busy is low and no result pends.
module hash_vote_tally (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hvt_pkg::cmd_t      cmd,
    output logic               done,
    output hvt_pkg::rsp_t      rsp,
    input  logic               cfg_we,
    input  logic               cfg_idx,
    input  logic [8:0]         cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MOD      = 4'd1;
    localparam logic [3:0] S_PROBE    = 4'd2;
    localparam logic [3:0] S_CMP      = 4'd3;
    localparam logic [3:0] S_SEED     = 4'd4;
    localparam logic [3:0] S_SCAN     = 4'd5;
    localparam logic [3:0] S_SCAN_CMP = 4'd6;
    localparam logic [3:0] S_WIN      = 4'd7;
    localparam logic [3:0] S_CLEAR    = 4'd8;

    localparam int KW = hvt_pkg::KEY_BITS;
    localparam int SW = hvt_pkg::SZ_W;
    localparam int CLR_LAST = ((hvt_pkg::CAND_SLOTS > hvt_pkg::VOTER_SLOTS)
                               ? hvt_pkg::CAND_SLOTS : hvt_pkg::VOTER_SLOTS) - 1;

    // table select for the probe walk
    localparam logic TBL_CAND  = 1'b0;
    localparam logic TBL_VOTER = 1'b1;

    logic [3:0]                 state_reg, state_next;
    hvt_pkg::cmd_t              cmd_reg, cmd_next;
    logic                       tbl_reg, tbl_next;
    logic [KW-1:0]              num_reg, num_next;
    logic [SW-1:0]              rem_reg, rem_next;
    logic [hvt_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]              size_reg, size_next;
    logic [SW-1:0]              j_reg, j_next;
    logic [SW-1:0]              i_reg, i_next;
    logic [hvt_pkg::VIDX_W-1:0] vslot_reg, vslot_next;
    logic [hvt_pkg::CIDX_W-1:0] best_reg, best_next;
    logic [hvt_pkg::VOTE_W-1:0] best_cnt_reg, best_cnt_next;
    logic                       first_valid_reg, first_valid_next;
    logic [hvt_pkg::CIDX_W-1:0] first_slot_reg, first_slot_next;
    logic [hvt_pkg::PIDX_W-1:0] clr_reg, clr_next;
    logic                       rsp_pend_reg, rsp_pend_next;
    logic [hvt_pkg::CFG_W-1:0]  csize_cfg_reg, vsize_cfg_reg;
    logic                       done_reg, done_next;
    hvt_pkg::rsp_t              rsp_reg, rsp_next;

    // RAM ports; the top bit of a key entry is its used flag
    logic [hvt_pkg::CIDX_W-1:0] cand_addr;
    logic [hvt_pkg::VIDX_W-1:0] voter_addr;
    logic                       ckey_we, ccnt_we, vkey_we, vvoted_we;
    logic [2*KW:0]              ckey_rdata, vkey_rdata, ckey_wdata, vkey_wdata;
    logic [2*KW-1:0]            probe_key;
    logic [hvt_pkg::VOTE_W-1:0] ccnt_wdata, ccnt_rdata;
    logic                       vvoted_wdata, vvoted_rdata;

    logic [SW-1:0]              csz, vsz;
    logic [SW:0]                rem_sh;
    logic [SW-1:0]              rem_step;
    logic [SW-1:0]              j_inc;
    logic [2*KW:0]              key_rdata;
    logic                       slot_used, key_match, hit, empty, miss;

    // Clamp the size registers into 1..slots.
    always_comb
    begin
        if (csize_cfg_reg == '0)
            csz = SW'(1);
        else if (32'(csize_cfg_reg) > 32'(hvt_pkg::CAND_SLOTS))
            csz = SW'(hvt_pkg::CAND_SLOTS);
        else
            csz = SW'(csize_cfg_reg);
        if (vsize_cfg_reg == '0)
            vsz = SW'(1);
        else if (32'(vsize_cfg_reg) > 32'(hvt_pkg::VOTER_SLOTS))
            vsz = SW'(hvt_pkg::VOTER_SLOTS);
        else
            vsz = SW'(vsize_cfg_reg);
    end

    // One restoring-division step: shift in the next dividend bit.
    assign rem_sh   = {rem_reg, num_reg[KW-1]};
    assign rem_step = (rem_sh >= {1'b0, size_reg}) ? SW'(rem_sh - {1'b0, size_reg})
                                                   : SW'(rem_sh);
    assign j_inc    = (j_reg + SW'(1) == size_reg) ? '0 : j_reg + SW'(1);

    assign key_rdata = (tbl_reg == TBL_VOTER) ? vkey_rdata : ckey_rdata;
    assign probe_key = (cmd_reg.op == hvt_pkg::OP_VOTE && tbl_reg == TBL_CAND)
                     ? {cmd_reg.cand_val[KW-1:0], cmd_reg.cand_n[KW-1:0]}
                     : {cmd_reg.key_val[KW-1:0], cmd_reg.key_n[KW-1:0]};

    // Probe outcome: the slot read in S_PROBE is judged in S_CMP.
    assign slot_used = key_rdata[2*KW];
    assign key_match = (key_rdata[2*KW-1:0] == probe_key);
    assign hit       = (state_reg == S_CMP) && slot_used && key_match;
    assign empty     = (state_reg == S_CMP) && !slot_used;
    assign miss      = (state_reg == S_PROBE) && (i_reg == size_reg);

    // Clearing writes an all-zero entry, which drops the used flag.
    assign ckey_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, probe_key};
    assign vkey_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, probe_key};

    // Address selection: clearing pass, seed fetch from idle, winner fetch at
    // end of scan, and the held voter slot while the candidate is judged.
    always_comb
    begin
        if (state_reg == S_CLEAR)
            cand_addr = clr_reg[hvt_pkg::CIDX_W-1:0];
        else if (state_reg == S_IDLE)
            cand_addr = first_slot_reg;
        else if (state_reg == S_SCAN && j_reg == size_reg)
            cand_addr = best_reg;
        else
            cand_addr = j_reg[hvt_pkg::CIDX_W-1:0];
        if (state_reg == S_CLEAR)
            voter_addr = clr_reg[hvt_pkg::VIDX_W-1:0];
        else if (state_reg == S_CMP && tbl_reg == TBL_CAND)
            voter_addr = vslot_reg;
        else
            voter_addr = j_reg[hvt_pkg::VIDX_W-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        tbl_next         = tbl_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        size_next        = size_reg;
        j_next           = j_reg;
        i_next           = i_reg;
        vslot_next       = vslot_reg;
        best_next        = best_reg;
        best_cnt_next    = best_cnt_reg;
        first_valid_next = first_valid_reg;
        first_slot_next  = first_slot_reg;
        clr_next         = clr_reg;
        rsp_pend_next    = rsp_pend_reg;
        done_next        = 1'b0;
        rsp_next         = rsp_reg;
        ckey_we          = 1'b0;
        ccnt_we          = 1'b0;
        vkey_we          = 1'b0;
        vvoted_we        = 1'b0;
        ccnt_wdata       = '0;
        vvoted_wdata     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    rem_next = '0;
                    cnt_next = '0;
                    num_next = cmd.key_val[KW-1:0];
                    if (cmd.op == hvt_pkg::OP_FINISH)
                    begin
                        size_next = csz;
                        if (!first_valid_reg)
                        begin
                            // no candidates: hold the answer, still drop both tables
                            rsp_next        = '0;
                            rsp_next.status = hvt_pkg::ST_NO_CANDS;
                            rsp_pend_next   = 1'b1;
                            clr_next        = '0;
                            state_next      = S_CLEAR;
                        end
                        else
                        begin
                            state_next = S_SEED;
                        end
                    end
                    else
                    begin
                        tbl_next   = (cmd.op == hvt_pkg::OP_ADD_CAND) ? TBL_CAND : TBL_VOTER;
                        size_next  = (cmd.op == hvt_pkg::OP_ADD_CAND) ? csz : vsz;
                        state_next = S_MOD;
                    end
                end
            end

            S_MOD:
            begin
                rem_next = rem_step;
                num_next = {num_reg[KW-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == hvt_pkg::CNT_W'(KW - 1))
                begin
                    j_next     = rem_step;
                    i_next     = '0;
                    state_next = S_PROBE;
                end
            end

            S_PROBE, S_CMP:
            begin
                if (state_reg == S_PROBE && !miss)
                    state_next = S_CMP;
                if (state_reg == S_CMP && slot_used && !key_match)
                begin
                    j_next     = j_inc;
                    i_next     = i_reg + SW'(1);
                    state_next = S_PROBE;
                end
                // walk ends on a miss, a hit or an empty slot; an empty slot means the key is absent and slot j is free
                if (miss || hit || empty)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '0;
                    state_next = S_IDLE;
                    unique case (cmd_reg.op)
                        hvt_pkg::OP_ADD_CAND:
                        begin
                            if (miss)
                                rsp_next.status = hvt_pkg::ST_FULL;
                            else
                            begin
                                ckey_we    = 1'b1;
                                ccnt_we    = 1'b1;
                                if (!first_valid_reg)
                                begin
                                    first_valid_next = 1'b1;
                                    first_slot_next  = j_reg[hvt_pkg::CIDX_W-1:0];
                                end
                            end
                        end
                        hvt_pkg::OP_ADD_VOTER:
                        begin
                            if (miss)
                                rsp_next.status = hvt_pkg::ST_FULL;
                            else
                            begin
                                vkey_we   = 1'b1;
                                vvoted_we = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (tbl_reg == TBL_VOTER)
                            begin
                                if (!hit)
                                    rsp_next.status = hvt_pkg::ST_UNKNOWN_VOTER;
                                else if (vvoted_rdata)
                                    rsp_next.status = hvt_pkg::ST_ALREADY_VOTED;
                                else
                                begin
                                    // voter ok: hash the candidate next
                                    done_next  = 1'b0;
                                    vslot_next = j_reg[hvt_pkg::VIDX_W-1:0];
                                    tbl_next   = TBL_CAND;
                                    size_next  = csz;
                                    num_next   = cmd_reg.cand_val[KW-1:0];
                                    rem_next   = '0;
                                    cnt_next   = '0;
                                    state_next = S_MOD;
                                end
                            end
                            else if (!hit)
                                rsp_next.status = hvt_pkg::ST_UNKNOWN_CAND;
                            else
                            begin
                                ccnt_we      = 1'b1;
                                ccnt_wdata   = (ccnt_rdata == '1) ? ccnt_rdata
                                                                  : ccnt_rdata + 1'b1;
                                vvoted_we    = 1'b1;
                                vvoted_wdata = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_SEED:
            begin
                best_next     = first_slot_reg;
                best_cnt_next = ccnt_rdata;
                j_next        = '0;
                state_next    = S_SCAN;
            end

            S_SCAN:
            begin
                if (j_reg == size_reg)
                    state_next = S_WIN;
                else
                    state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                if (ckey_rdata[2*KW] && ccnt_rdata > best_cnt_reg)
                begin
                    best_next     = j_reg[hvt_pkg::CIDX_W-1:0];
                    best_cnt_next = ccnt_rdata;
                end
                j_next     = j_reg + SW'(1);
                state_next = S_SCAN;
            end

            S_WIN:
            begin
                rsp_next.status         = hvt_pkg::ST_OK;
                rsp_next.winner_val     = 32'(ckey_rdata[2*KW-1:KW]);
                rsp_next.winner_n       = 32'(ckey_rdata[KW-1:0]);
                rsp_next.winner_votes   = best_cnt_reg;
                rsp_pend_next           = 1'b1;
                first_valid_next        = 1'b0;
                first_slot_next         = '0;
                clr_next                = '0;
                state_next              = S_CLEAR;
            end

            S_CLEAR:
            begin
                ckey_we  = (int'(clr_reg) < hvt_pkg::CAND_SLOTS);
                vkey_we  = (int'(clr_reg) < hvt_pkg::VOTER_SLOTS);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == hvt_pkg::PIDX_W'(CLR_LAST))
                begin
                    // release the held finish answer, if any
                    done_next     = rsp_pend_reg;
                    rsp_pend_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            first_valid_reg <= 1'b0;
            first_slot_reg  <= '0;
            clr_reg         <= '0;
            rsp_pend_reg    <= 1'b0;
            done_reg        <= 1'b0;
            csize_cfg_reg   <= hvt_pkg::CFG_W'(256);
            vsize_cfg_reg   <= hvt_pkg::CFG_W'(256);
        end
        else
        begin
            state_reg       <= state_next;
            first_valid_reg <= first_valid_next;
            first_slot_reg  <= first_slot_next;
            clr_reg         <= clr_next;
            rsp_pend_reg    <= rsp_pend_next;
            done_reg        <= done_next;
            if (cfg_we && cfg_idx == hvt_pkg::CFG_CAND_SIZE)
                csize_cfg_reg <= cfg_data;
            if (cfg_we && cfg_idx == hvt_pkg::CFG_VOTER_SIZE)
                vsize_cfg_reg <= cfg_data;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tbl_reg      <= tbl_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        size_reg     <= size_next;
        j_reg        <= j_next;
        i_reg        <= i_next;
        vslot_reg    <= vslot_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
        rsp_reg      <= rsp_next;
    end

    hvt_ram #(.WIDTH(2 * KW + 1), .DEPTH(hvt_pkg::CAND_SLOTS)) u_ckey (
        .clk   (clk),
        .we    (ckey_we),
        .addr  (cand_addr),
        .wdata (ckey_wdata),
        .rdata (ckey_rdata)
    );

    hvt_ram #(.WIDTH(hvt_pkg::VOTE_W), .DEPTH(hvt_pkg::CAND_SLOTS)) u_ccnt (
        .clk   (clk),
        .we    (ccnt_we),
        .addr  (cand_addr),
        .wdata (ccnt_wdata),
        .rdata (ccnt_rdata)
    );

    hvt_ram #(.WIDTH(2 * KW + 1), .DEPTH(hvt_pkg::VOTER_SLOTS)) u_vkey (
        .clk   (clk),
        .we    (vkey_we),
        .addr  (voter_addr),
        .wdata (vkey_wdata),
        .rdata (vkey_rdata)
    );

    hvt_ram #(.WIDTH(1), .DEPTH(hvt_pkg::VOTER_SLOTS)) u_vvoted (
        .clk   (clk),
        .we    (vvoted_we),
        .addr  (voter_addr),
        .wdata (vvoted_wdata),
        .rdata (vvoted_rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A result only ever leaves while the sequencer rests.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted word either starts work or answers at once.
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word lost");

    // The clearing pass never runs with a live seed.
    a_clear_no_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !first_valid_reg)
        else $error("seed still valid while clearing");

    // Each result strobe lasts one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

endmodule

[design/hvt_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module hvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
